FILE: hw/rtl/scrolling_digit_matrix_display_unit_macros.svh
// ----------------------------------------------------------------------------
// Scrolling digit matrix display: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_DIGIT_MATRIX_DISPLAY_UNIT_MACROS_SVH
`define SCROLLING_DIGIT_MATRIX_DISPLAY_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SDMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define SDMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sdmd_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling digit matrix display package
// Types, codes, glyph table and small arithmetic helpers shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdmd_pkg;

  localparam int FRAME_BYTES_DEF = 10;
  localparam int GLYPH_ROWS_DEF  = 5;
  localparam int ROW_W           = 3;
  localparam int NUM_DIGITS      = 6;
  localparam int NUM_VALUES      = 8;

  // Input selectors and result kinds.
  localparam logic OP_BYTE     = 1'b0;
  localparam logic OP_TICK     = 1'b1;
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_BRIGHT = 1'b1;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // Display modes.
  localparam logic [7:0] MODE_CLOCK_FIRST = 8'd1;
  localparam logic [7:0] MODE_CLOCK_LAST  = 8'd3;
  localparam logic [7:0] MODE_LIGHT       = 8'd4;
  localparam logic [7:0] MODE_TEMP_C      = 8'd5;
  localparam logic [7:0] MODE_TEMP_F      = 8'd6;

  // Symbol codes beyond the ten digits.
  localparam logic [3:0] SYM_BAR   = 4'd10;
  localparam logic [3:0] SYM_X     = 4'd11;
  localparam logic [3:0] SYM_C     = 4'd12;
  localparam logic [3:0] SYM_F     = 4'd13;
  localparam logic [3:0] SYM_BLANK = 4'd15;
  localparam int         NUM_SYMS  = 14;

  localparam logic [31:0] COLON_BITS  = 32'h0004_0000 | 32'h0000_0100;
  localparam logic [31:0] POINT_BIT   = 32'h0000_1000;
  localparam logic [31:0] DEGREE_TOP  = 32'h0000_0020;
  localparam logic [31:0] DEGREE_MID  = 32'h0000_0050;

  localparam logic [12:0] BRIGHT_BASE = 13'd700;
  localparam logic [12:0] BRIGHT_MAX  = 13'd7000;

  // Text widths in columns.
  localparam logic [5:0] WIDTH_30 = 6'd30;
  localparam logic [5:0] WIDTH_28 = 6'd28;
  localparam logic [5:0] WIDTH_26 = 6'd26;
  localparam logic [5:0] WIDTH_24 = 6'd24;
  localparam logic [5:0] WIDTH_22 = 6'd22;
  localparam logic [5:0] WIDTH_18 = 6'd18;
  localparam logic [5:0] WINDOW_COLS = 6'd16;

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {
    CLS_CLOCK,
    CLS_LIGHT,
    CLS_TEMP
  } mode_class_e;

  typedef enum logic {
    ROW_COMPOSE,
    ROW_WINDOW
  } row_op_e;

  typedef struct packed {
    row_op_e          op;
    mode_class_e      cls;
    logic             fahrenheit;
    logic [ROW_W-1:0] row;
  } row_ctl_t;

  localparam logic [2:0] GLYPHS [NUM_SYMS][8] = '{
    '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7, 3'h0, 3'h0, 3'h0},
    '{3'h6, 3'h2, 3'h2, 3'h2, 3'h7, 3'h0, 3'h0, 3'h0},
    '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7, 3'h0, 3'h0, 3'h0},
    '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7, 3'h0, 3'h0, 3'h0},
    '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1, 3'h0, 3'h0, 3'h0},
    '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7, 3'h0, 3'h0, 3'h0},
    '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7, 3'h0, 3'h0, 3'h0},
    '{3'h7, 3'h1, 3'h1, 3'h1, 3'h1, 3'h0, 3'h0, 3'h0},
    '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7, 3'h0, 3'h0, 3'h0},
    '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7, 3'h0, 3'h0, 3'h0},
    '{3'h2, 3'h2, 3'h2, 3'h2, 3'h2, 3'h0, 3'h0, 3'h0},
    '{3'h0, 3'h0, 3'h5, 3'h2, 3'h5, 3'h0, 3'h0, 3'h0},
    '{3'h3, 3'h4, 3'h4, 3'h4, 3'h3, 3'h0, 3'h0, 3'h0},
    '{3'h7, 3'h4, 3'h7, 3'h4, 3'h4, 3'h0, 3'h0, 3'h0}
  };

  // Glyph rows of 12:00:00, the picture shown straight after reset.
  localparam logic [31:0] RESET_ROWS [8] = '{
    32'h0671_DC77, 32'h0215_5555, 32'h0271_5455, 32'h0245_5555,
    32'h0771_DC77, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  // hh, mm, ss, l1, l2, l3, t1, t2
  localparam logic [7:0] SHOWN_RESET [NUM_VALUES] = '{
    8'd12, 8'd0, 8'd0, 8'd7, 8'd65, 8'd4, 8'd23, 8'd4
  };

  function automatic logic [2:0] sym_row(input digit_t code, input logic [ROW_W-1:0] row);
    logic [2:0] bits;
    bits = 3'h0;
    if (code < 4'(NUM_SYMS)) begin
      bits = GLYPHS[code][row];
    end
    return bits;
  endfunction

  // Quotient by ten through the reciprocal 205/2048, exact for byte values.
  function automatic logic [7:0] div10(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd205;
    return {3'b000, prod[15:11]};
  endfunction

  // Quotient by one hundred through 41/4096, exact for byte values.
  function automatic logic [7:0] div100(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd41;
    return {4'b0000, prod[15:12]};
  endfunction

  // Digit code for a value; anything above nine shows as a blank.
  function automatic digit_t dcode(input logic [7:0] x);
    return (x <= 8'd9) ? x[3:0] : SYM_BLANK;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/scrolling_digit_matrix_display_unit.sv
// ----------------------------------------------------------------------------
// Scrolling digit matrix display unit
// Frame decoding, glyph rendering and scroll windows for a dot matrix panel.
// ----------------------------------------------------------------------------
// Link bytes and scroll ticks arrive on one input stream, selected by tuser.
// A link byte is taken only while the unit is idle; bytes outside a frame are
// dropped until the 0xFF sync byte. The last byte of a frame starts a busy
// sequence (latch, digit split, rendering of each glyph row, brightness) that
// ends in one brightness transfer before the next item is taken; an unknown
// mode skips the rendering rows. A scroll tick yields GLYPH_ROWS + 1 row-window
// transfers, one per cycle, the last of them being the mode indicator row with
// tlast set. The shared row unit builds or windows one row per cycle, and the
// transfers stretch while the output is back-pressured. The input is not
// ready during a sequence. No clearing pass follows reset: the reset picture
// is 12:00:00 in clock mode.
`timescale 1ns / 1ps
`default_nettype none

`include "scrolling_digit_matrix_display_unit_macros.svh"

module scrolling_digit_matrix_display_unit #(
  parameter int FRAME_BYTES = sdmd_pkg::FRAME_BYTES_DEF,
  parameter int GLYPH_ROWS  = sdmd_pkg::GLYPH_ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  wire logic        s_axis_tuser,   // [0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [2:0] row_index, [18:3] row_pixels,
                                           // [31:19] brightness
  output logic             m_axis_tuser,   // [0] kind
  output logic             m_axis_tlast    // last
);

  localparam int CNT_W = $clog2(GLYPH_ROWS + 1);
  localparam int LS_W  = $clog2(GLYPH_ROWS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LATCH,
    ST_DIGITS,
    ST_RENDER,
    ST_BRIGHT,
    ST_SCAN
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       row_q;
  logic [7:0]             mode_q;
  logic [7:0]             shown_q [sdmd_pkg::NUM_VALUES];
  logic [31:0]            line_q [GLYPH_ROWS];
  logic [5:0]             width_q;
  logic [5:0]             scroll_q;
  sdmd_pkg::digit_t       digit_q [sdmd_pkg::NUM_DIGITS];
  sdmd_pkg::mode_class_e  class_q;
  logic                   fahr_q;
  logic [17:0]            bright_raw_q;

  logic                   out_valid_q;
  logic                   out_kind_q;
  logic [2:0]             out_row_q;
  logic [15:0]            out_pix_q;
  logic [12:0]            out_bright_q;
  logic                   out_last_q;

  logic                   in_accept;
  logic                   byte_accept;
  logic                   tick_accept;
  logic                   frame_done;
  logic [7:0]             frame_bytes [FRAME_BYTES-1];
  logic                   out_free;
  logic                   out_load;
  logic                   mode_valid;

  sdmd_pkg::digit_t       digit_d [sdmd_pkg::NUM_DIGITS];
  sdmd_pkg::mode_class_e  class_d;
  logic [5:0]             width_d;
  logic [7:0]             q10 [3];
  logic [7:0]             t1_q10;
  logic [7:0]             t1_q100;
  logic [17:0]            bright_raw_d;
  logic [17:0]            bright_sum;
  logic [12:0]            bright_cap;
  logic [5:0]             offset;
  logic [5:0]             scroll_inc;
  logic [15:0]            indicator;
  sdmd_pkg::row_ctl_t     row_ctl;
  logic [31:0]            row_word;

  logic                   bright_xfer;
  logic                   row_xfer;
  logic                   bright_ok;
  logic                   row_ok;
  logic                   scan_start;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign byte_accept   = in_accept && (s_axis_tuser == sdmd_pkg::OP_BYTE);
  assign tick_accept   = in_accept && (s_axis_tuser == sdmd_pkg::OP_TICK);
  assign out_free      = !out_valid_q || m_axis_tready;
  // The output register takes a new transfer in this cycle.
  assign out_load      = out_free && ((state_q == ST_BRIGHT) || (state_q == ST_SCAN));
  assign mode_valid    = (mode_q >= sdmd_pkg::MODE_CLOCK_FIRST) &&
                         (mode_q <= sdmd_pkg::MODE_TEMP_F);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_bright_q, out_pix_q, out_row_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  sdmd_frame_rx #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_accept),
    .byte_i       (s_axis_tdata),
    .done_o       (frame_done),
    .bytes_o      (frame_bytes)
  );

  // Digit split, text width and brightness terms for the latched values.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q10[i] = sdmd_pkg::div10(shown_q[i]);
    end
    t1_q10  = sdmd_pkg::div10(shown_q[6]);
    t1_q100 = sdmd_pkg::div100(shown_q[6]);
    for (int i = 0; i < sdmd_pkg::NUM_DIGITS; i++) begin
      digit_d[i] = sdmd_pkg::SYM_BLANK;
    end
    if (mode_q <= sdmd_pkg::MODE_CLOCK_LAST) begin
      class_d = sdmd_pkg::CLS_CLOCK;
      for (int i = 0; i < 3; i++) begin
        digit_d[2*i]   = sdmd_pkg::dcode(q10[i]);
        digit_d[2*i+1] = sdmd_pkg::dcode(shown_q[i] - 8'(q10[i] * 8'd10));
      end
      width_d = (shown_q[0] >= 8'd10) ? sdmd_pkg::WIDTH_28 : sdmd_pkg::WIDTH_24;
    end else if (mode_q == sdmd_pkg::MODE_LIGHT) begin
      class_d    = sdmd_pkg::CLS_LIGHT;
      digit_d[0] = sdmd_pkg::dcode(sdmd_pkg::div10(shown_q[3]));
      digit_d[1] = sdmd_pkg::dcode(shown_q[3] - 8'(sdmd_pkg::div10(shown_q[3]) * 8'd10));
      digit_d[2] = sdmd_pkg::dcode(sdmd_pkg::div10(shown_q[4]));
      digit_d[3] = sdmd_pkg::dcode(shown_q[4] - 8'(sdmd_pkg::div10(shown_q[4]) * 8'd10));
      digit_d[4] = sdmd_pkg::dcode(shown_q[5]);
      if (shown_q[3] >= 8'd10) begin
        width_d = sdmd_pkg::WIDTH_30;
      end else if (shown_q[3] != 8'd0) begin
        width_d = sdmd_pkg::WIDTH_26;
      end else if (shown_q[4] >= 8'd10) begin
        width_d = sdmd_pkg::WIDTH_22;
      end else begin
        width_d = sdmd_pkg::WIDTH_18;
      end
    end else begin
      class_d    = sdmd_pkg::CLS_TEMP;
      digit_d[0] = sdmd_pkg::dcode(t1_q100);
      digit_d[1] = sdmd_pkg::dcode(t1_q10 - 8'(t1_q100 * 8'd10));
      digit_d[2] = sdmd_pkg::dcode(shown_q[6] - 8'(t1_q10 * 8'd10));
      digit_d[3] = sdmd_pkg::dcode(shown_q[7]);
      if (shown_q[6] >= 8'd100) begin
        width_d = sdmd_pkg::WIDTH_26;
      end else if (shown_q[6] >= 8'd10) begin
        width_d = sdmd_pkg::WIDTH_22;
      end else begin
        width_d = sdmd_pkg::WIDTH_18;
      end
    end
    bright_raw_d = 18'(shown_q[3]) * 18'd1000 + 18'(shown_q[4]) * 18'd10;
    bright_sum   = bright_raw_q + 18'(sdmd_pkg::BRIGHT_BASE);
    bright_cap   = (bright_sum > 18'(sdmd_pkg::BRIGHT_MAX)) ? sdmd_pkg::BRIGHT_MAX
                                                            : bright_sum[12:0];
  end

  // Scroll window offset, indicator row and the advanced scroll position.
  always_comb begin
    offset     = (width_q >= sdmd_pkg::WINDOW_COLS) ? (width_q - sdmd_pkg::WINDOW_COLS)
                                                    : 6'd0;
    indicator  = mode_valid ? (16'd1 << (3'd6 - mode_q[2:0])) : 16'd0;
    scroll_inc = scroll_q + 6'd1;
  end

  always_comb begin
    row_ctl.op         = (state_q == ST_SCAN) ? sdmd_pkg::ROW_WINDOW : sdmd_pkg::ROW_COMPOSE;
    row_ctl.cls        = class_q;
    row_ctl.fahrenheit = fahr_q;
    row_ctl.row        = row_q[sdmd_pkg::ROW_W-1:0];
  end

  sdmd_row_unit u_row_unit (
    .ctl_i    (row_ctl),
    .digits_i (digit_q),
    .line_i   (line_q[row_q[LS_W-1:0]]),
    .scroll_i (scroll_q),
    .offset_i (offset),
    .word_o   (row_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_q        <= '0;
      mode_q       <= sdmd_pkg::MODE_CLOCK_FIRST;
      for (int i = 0; i < sdmd_pkg::NUM_VALUES; i++) begin
        shown_q[i] <= sdmd_pkg::SHOWN_RESET[i];
      end
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        line_q[r] <= sdmd_pkg::RESET_ROWS[r];
      end
      width_q      <= sdmd_pkg::WIDTH_28;
      scroll_q     <= '0;
      for (int i = 0; i < sdmd_pkg::NUM_DIGITS; i++) begin
        digit_q[i] <= sdmd_pkg::SYM_BLANK;
      end
      class_q      <= sdmd_pkg::CLS_CLOCK;
      fahr_q       <= 1'b0;
      bright_raw_q <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= sdmd_pkg::KIND_ROW;
      out_row_q    <= '0;
      out_pix_q    <= '0;
      out_bright_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          row_q <= '0;
          if (tick_accept) begin
            state_q <= ST_SCAN;
          end else if (frame_done) begin
            state_q <= ST_LATCH;
          end
        end
        ST_LATCH: begin
          if (mode_q != frame_bytes[0]) begin
            mode_q   <= frame_bytes[0];
            scroll_q <= '0;
          end
          for (int i = 0; i < sdmd_pkg::NUM_VALUES; i++) begin
            shown_q[i] <= frame_bytes[i+1];
          end
          state_q <= ST_DIGITS;
        end
        ST_DIGITS: begin
          bright_raw_q <= bright_raw_d;
          if (mode_valid) begin
            digit_q <= digit_d;
            class_q <= class_d;
            fahr_q  <= (mode_q == sdmd_pkg::MODE_TEMP_F);
            width_q <= width_d;
            state_q <= ST_RENDER;
          end else begin
            state_q <= ST_BRIGHT;
          end
        end
        ST_RENDER: begin
          line_q[row_q[LS_W-1:0]] <= row_word;
          if (row_q == CNT_W'(GLYPH_ROWS - 1)) begin
            state_q <= ST_BRIGHT;
          end else begin
            row_q <= row_q + CNT_W'(1);
          end
        end
        ST_BRIGHT: begin
          if (out_load) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= sdmd_pkg::KIND_BRIGHT;
            out_row_q    <= '0;
            out_pix_q    <= '0;
            out_bright_q <= bright_cap;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (out_load) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= sdmd_pkg::KIND_ROW;
            out_row_q    <= row_q[2:0];
            out_bright_q <= '0;
            if (row_q == CNT_W'(GLYPH_ROWS)) begin
              out_pix_q  <= indicator;
              out_last_q <= 1'b1;
              scroll_q   <= (scroll_inc > width_q) ? 6'd0 : scroll_inc;
              state_q    <= ST_IDLE;
            end else begin
              out_pix_q  <= row_word[15:0];
              out_last_q <= 1'b0;
              row_q      <= row_q + CNT_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign bright_xfer = m_axis_tvalid && (m_axis_tuser == sdmd_pkg::KIND_BRIGHT);
  assign row_xfer    = m_axis_tvalid && (m_axis_tuser == sdmd_pkg::KIND_ROW);
  assign bright_ok   = m_axis_tlast && (m_axis_tdata[18:0] == 19'd0) &&
                       (m_axis_tdata[31:19] >= sdmd_pkg::BRIGHT_BASE) &&
                       (m_axis_tdata[31:19] <= sdmd_pkg::BRIGHT_MAX);
  assign row_ok      = (m_axis_tdata[31:19] == 13'd0) &&
                       (m_axis_tlast == (32'(m_axis_tdata[2:0]) == 32'(GLYPH_ROWS % 8)));
  assign scan_start  = (state_q == ST_SCAN) && (row_q == '0);

  `SDMD_ASSERT(a_bright_form, bright_xfer |-> bright_ok, "brightness transfer malformed")
  `SDMD_ASSERT(a_row_form, row_xfer |-> row_ok, "row window transfer malformed")
  `SDMD_ASSERT_NEXT(a_tick_scan, tick_accept, scan_start, "scroll tick did not start a scan")

endmodule

`default_nettype wire

FILE: hw/rtl/sdmd_frame_rx.sv
// ----------------------------------------------------------------------------
// Frame receiver
// Hunts for the sync byte, then collects the data bytes of one frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdmd_frame_rx #(
  parameter int FRAME_BYTES = sdmd_pkg::FRAME_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  output logic            done_o,
  output logic [7:0]      bytes_o [FRAME_BYTES-1]
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam int IDX_W = $clog2(FRAME_BYTES - 1);

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] wr_idx;
  logic [7:0]       bytes_q [FRAME_BYTES-1];

  assign wr_idx = count_q - CNT_W'(1);
  assign done_o = byte_valid_i && (count_q == CNT_W'(FRAME_BYTES - 1));
  assign bytes_o = bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (byte_valid_i) begin
      if (count_q == '0) begin
        if (byte_i == sdmd_pkg::SYNC_BYTE) begin
          count_q <= CNT_W'(1);
        end
      end else if (done_o) begin
        count_q <= '0;
      end else begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // A sync byte inside an open frame is kept as ordinary data.
  always_ff @(posedge clk_i) begin
    if (byte_valid_i && (count_q != '0)) begin
      bytes_q[wr_idx[IDX_W-1:0]] <= byte_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sdmd_row_unit.sv
// ----------------------------------------------------------------------------
// Row unit
// Shared row datapath: builds one 32-bit glyph row of the text, or cuts the
// sixteen visible columns out of a stored row for the current scroll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdmd_row_unit (
  input  wire sdmd_pkg::row_ctl_t ctl_i,
  input  wire sdmd_pkg::digit_t   digits_i [sdmd_pkg::NUM_DIGITS],
  input  wire logic [31:0]        line_i,
  input  wire logic [5:0]         scroll_i,
  input  wire logic [5:0]         offset_i,
  output logic [31:0]             word_o
);

  logic [31:0] g [sdmd_pkg::NUM_DIGITS];
  logic [31:0] shifted;
  logic [31:0] unit_sym;

  always_comb begin
    for (int i = 0; i < sdmd_pkg::NUM_DIGITS; i++) begin
      g[i] = 32'(sdmd_pkg::sym_row(digits_i[i], ctl_i.row));
    end
    unit_sym = 32'(sdmd_pkg::sym_row(ctl_i.fahrenheit ? sdmd_pkg::SYM_F : sdmd_pkg::SYM_C,
                                     ctl_i.row));
    shifted = '0;
    word_o  = '0;
    unique case (ctl_i.op)
      sdmd_pkg::ROW_COMPOSE: begin
        case (ctl_i.cls)
          sdmd_pkg::CLS_CLOCK: begin
            word_o = (g[0] << 24) | (g[1] << 20) | (g[2] << 14) | (g[3] << 10)
                   | (g[4] << 4) | g[5];
            if ((ctl_i.row == 3'd1) || (ctl_i.row == 3'd3)) begin
              word_o = word_o | sdmd_pkg::COLON_BITS;
            end
          end
          sdmd_pkg::CLS_LIGHT: begin
            word_o = (g[0] << 26) | (g[1] << 22) | (g[2] << 18) | (g[3] << 14)
                   | (g[4] << 8)
                   | (32'(sdmd_pkg::sym_row(sdmd_pkg::SYM_BAR, ctl_i.row)) << 4)
                   | 32'(sdmd_pkg::sym_row(sdmd_pkg::SYM_X, ctl_i.row));
            if (ctl_i.row == 3'd4) begin
              word_o = word_o | sdmd_pkg::POINT_BIT;
            end
          end
          sdmd_pkg::CLS_TEMP: begin
            word_o = (g[0] << 22) | (g[1] << 18) | (g[2] << 14) | (g[3] << 8) | unit_sym;
            if (ctl_i.row == 3'd4) begin
              word_o = word_o | sdmd_pkg::POINT_BIT;
            end
            if ((ctl_i.row == 3'd0) || (ctl_i.row == 3'd2)) begin
              word_o = word_o | sdmd_pkg::DEGREE_TOP;
            end else if (ctl_i.row == 3'd1) begin
              word_o = word_o | sdmd_pkg::DEGREE_MID;
            end
          end
          default: word_o = '0;
        endcase
      end
      sdmd_pkg::ROW_WINDOW: begin
        // Shifts of 32 or more empty the word rather than wrap.
        shifted = scroll_i[5] ? 32'h0 : (line_i << scroll_i[4:0]);
        word_o  = offset_i[5] ? 32'h0 : (shifted >> offset_i[4:0]);
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Scrolling digit matrix display unit testbench
// Drives link bytes and scroll ticks into the unit, predicts every brightness
// and row-window transfer from its own model of the frame decoder, renderer
// and scroller, and checks each output transfer field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sdmd_pkg::*;

  localparam int FRAME_LEN   = FRAME_BYTES_DEF;
  localparam int PANEL_ROWS  = GLYPH_ROWS_DEF;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int RANDOM_ITEMS = 330;

  // Font rows for the ten digits followed by the bar, x, C and F symbols.
  localparam logic [2:0] FONT [NUM_SYMS][5] = '{
    '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7}, '{3'h6, 3'h2, 3'h2, 3'h2, 3'h7},
    '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7}, '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
    '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1}, '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
    '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7}, '{3'h7, 3'h1, 3'h1, 3'h1, 3'h1},
    '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7}, '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7},
    '{3'h2, 3'h2, 3'h2, 3'h2, 3'h2}, '{3'h0, 3'h0, 3'h5, 3'h2, 3'h5},
    '{3'h3, 3'h4, 3'h4, 3'h4, 3'h3}, '{3'h7, 3'h4, 3'h7, 3'h4, 3'h4}
  };

  typedef struct packed {
    logic        kind;
    logic [2:0]  row;
    logic [15:0] pixels;
    logic [12:0] bright;
    logic        last;
  } panel_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] byte_value
  logic        s_axis_tuser = 1'b0;  // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [2:0] row_index, [18:3] row_pixels,
                                     // [31:19] brightness
  logic        m_axis_tuser;         // [0] kind
  logic        m_axis_tlast;

  // Predicted panel state.
  logic [3:0]  link_count;
  logic [7:0]  link_buf [FRAME_LEN-1];
  logic [7:0]  shown_mode;
  logic [7:0]  shown_vals [NUM_VALUES];
  logic [31:0] panel_lines [PANEL_ROWS];
  logic [5:0]  text_cols;
  logic [5:0]  scroll_cols;

  panel_result_t panel_results_q [$];
  int mismatch_count = 0;
  int counted_items  = 0;
  int idle_odds      = 0;    // 0 means no idling on either side
  int rx_hold_cycles = 0;
  bit tx_offering    = 1'b0;

  scrolling_digit_matrix_display_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [31:0] digit_bits(input int d, input int r);
    return (d <= 9) ? 32'(FONT[d][r]) : 32'd0;
  endfunction

  function automatic logic [31:0] symbol_bits(input logic [3:0] code, input int r);
    return 32'(FONT[code][r]);
  endfunction

  function automatic void render_panel();
    int hh, mm, ss, l1, l2, l3, t1, t2;
    logic [31:0] w;
    hh = shown_vals[0]; mm = shown_vals[1]; ss = shown_vals[2];
    l1 = shown_vals[3]; l2 = shown_vals[4]; l3 = shown_vals[5];
    t1 = shown_vals[6]; t2 = shown_vals[7];
    // An unknown mode leaves the picture and its width as they were.
    if (shown_mode < MODE_CLOCK_FIRST || shown_mode > MODE_TEMP_F) return;
    for (int r = 0; r < PANEL_ROWS; r++) begin
      if (shown_mode <= MODE_CLOCK_LAST) begin
        w = digit_bits(hh / 10, r) << 24 | digit_bits(hh % 10, r) << 20
          | digit_bits(mm / 10, r) << 14 | digit_bits(mm % 10, r) << 10
          | digit_bits(ss / 10, r) << 4 | digit_bits(ss % 10, r);
        if (r == 1 || r == 3) w |= COLON_BITS;
      end else if (shown_mode == MODE_LIGHT) begin
        w = digit_bits(l1 / 10, r) << 26 | digit_bits(l1 % 10, r) << 22
          | digit_bits(l2 / 10, r) << 18 | digit_bits(l2 % 10, r) << 14
          | digit_bits(l3, r) << 8 | symbol_bits(SYM_BAR, r) << 4
          | symbol_bits(SYM_X, r);
        if (r == 4) w |= POINT_BIT;
      end else begin
        w = digit_bits(t1 / 100, r) << 22 | digit_bits((t1 / 10) % 10, r) << 18
          | digit_bits(t1 % 10, r) << 14 | digit_bits(t2, r) << 8
          | symbol_bits(shown_mode == MODE_TEMP_C ? SYM_C : SYM_F, r);
        if (r == 4) w |= POINT_BIT;
        if (r == 0 || r == 2) w |= DEGREE_TOP;
        else if (r == 1) w |= DEGREE_MID;
      end
      panel_lines[r] = w;
    end
    if (shown_mode <= MODE_CLOCK_LAST) text_cols = (hh >= 10) ? WIDTH_28 : WIDTH_24;
    else if (shown_mode == MODE_LIGHT)
      text_cols = (l1 >= 10) ? WIDTH_30 : (l1 > 0) ? WIDTH_26 :
                  (l2 >= 10) ? WIDTH_22 : WIDTH_18;
    else text_cols = (t1 >= 100) ? WIDTH_26 : (t1 >= 10) ? WIDTH_22 : WIDTH_18;
  endfunction

  function automatic void reset_panel();
    link_count  = '0;
    shown_mode  = MODE_CLOCK_FIRST;
    shown_vals  = SHOWN_RESET;
    text_cols   = WIDTH_28;
    scroll_cols = '0;
    for (int r = 0; r < PANEL_ROWS; r++) panel_lines[r] = '0;
    render_panel();
  endfunction

  function automatic void predict_panel_step(input logic op, input logic [7:0] b);
    int br, off;
    logic [31:0] w;
    panel_result_t res;
    if (op == OP_BYTE) begin
      if (link_count == 0) begin
        if (b == SYNC_BYTE) begin
          link_count = 4'd1;
        end
        return;
      end
      link_buf[link_count - 1] = b;
      link_count++;
      if (link_count < FRAME_LEN) return;
      link_count = '0;
      if (shown_mode != link_buf[0]) begin
        shown_mode  = link_buf[0];
        scroll_cols = '0;
      end
      for (int i = 0; i < NUM_VALUES; i++) shown_vals[i] = link_buf[i + 1];
      br = int'(BRIGHT_BASE) + (int'(shown_vals[3]) * 100 + int'(shown_vals[4])) * 10;
      if (br > int'(BRIGHT_MAX)) br = int'(BRIGHT_MAX);
      render_panel();
      res = '{KIND_BRIGHT, 3'd0, 16'd0, 13'(br), 1'b1};
      panel_results_q.push_back(res);
    end else begin
      off = (text_cols >= WINDOW_COLS) ? int'(text_cols) - int'(WINDOW_COLS) : 0;
      for (int r = 0; r < PANEL_ROWS; r++) begin
        w = (scroll_cols < 32) ? panel_lines[r] << scroll_cols : 32'd0;
        w = (off < 32) ? w >> off : 32'd0;
        res = '{KIND_ROW, 3'(r), w[15:0], 13'd0, 1'b0};
        panel_results_q.push_back(res);
      end
      w = 32'd0;
      if (shown_mode >= MODE_CLOCK_FIRST && shown_mode <= MODE_TEMP_F)
        w = 32'd1 << (int'(MODE_TEMP_F) - int'(shown_mode));
      res = '{KIND_ROW, 3'(PANEL_ROWS), w[15:0], 13'd0, 1'b1};
      panel_results_q.push_back(res);
      scroll_cols = scroll_cols + 6'd1;
      if (scroll_cols > text_cols) scroll_cols = '0;
    end
  endfunction

  // ------------------------------------------------------------------ checking

  task automatic report_mismatch(input string what, input panel_result_t want,
                                 input panel_result_t got);
    mismatch_count++;
    // Only the first few are printed; the rest are counted.
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: expected kind=%0d row=%0d pix=%h bright=%0d last=%0d",
               $realtime, what, want.kind, want.row, want.pixels, want.bright,
               want.last);
      $display("[%0t] %s: got      kind=%0d row=%0d pix=%h bright=%0d last=%0d",
               $realtime, what, got.kind, got.row, got.pixels, got.bright,
               got.last);
    end
  endtask

  always @(posedge clk_i) begin : check_panel_output
    panel_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[18:3],
              m_axis_tdata[31:19], m_axis_tlast};
      if (panel_results_q.size() == 0) begin
        report_mismatch("unexpected transfer", '0, got);
      end else begin
        want = panel_results_q.pop_front();
        if (got.kind !== want.kind || got.row !== want.row ||
            got.pixels !== want.pixels || got.bright !== want.bright ||
            got.last !== want.last)
          report_mismatch("field mismatch", want, got);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles - 1) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------ stimulus

  task automatic push_panel_item(input logic op, input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    tx_offering = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    counted_items++;
    predict_panel_step(op, b);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      tx_offering = 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    if (tx_offering) begin
      s_axis_tvalid <= 1'b0;
      tx_offering = 1'b0;
    end
  endtask

  task automatic wait_results_drained();
    stop_sending();
    @(posedge clk_i);
    while (panel_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_panel_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // A whole frame; a tick may be slipped in after byte tick_after (0 = none).
  task automatic push_frame(input logic [7:0] mode, input logic [7:0] vals [NUM_VALUES],
                            input int tick_after);
    push_panel_item(OP_BYTE, SYNC_BYTE);
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      if (i + 1 == tick_after) push_panel_item(OP_TICK, 8'($urandom_range(0, 255)));
      push_panel_item(OP_BYTE, (i == 0) ? mode : vals[i - 1]);
    end
  endtask

  function automatic logic [7:0] pick_value(input int hi);
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, hi));
  endfunction

  function automatic logic [7:0] pick_mode();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) return 8'(r % 6) + MODE_CLOCK_FIRST;
    if (r == 12) return 8'd0;
    if (r == 13) return MODE_TEMP_F + 8'd1;
    if (r == 14) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_random_frame(input int tick_after);
    logic [7:0] vals [NUM_VALUES];
    vals[0] = pick_value(23);
    vals[1] = pick_value(59);
    vals[2] = pick_value(59);
    vals[3] = ($urandom_range(0, 3) == 0) ? 8'd0 : pick_value(70);
    vals[4] = pick_value(99);
    vals[5] = pick_value(9);
    vals[6] = pick_value(200);
    vals[7] = pick_value(9);
    push_frame(pick_mode(), vals, tick_after);
  endtask

  task automatic test_power_up_picture();
    push_ticks(3);
    wait_results_drained();
  endtask

  // Junk before sync, a sync value inside a frame, a tick in the middle of a
  // frame, brightness at both limits, blank digits and an unknown mode.
  task automatic test_frame_corners();
    logic [7:0] vals [NUM_VALUES];
    push_panel_item(OP_BYTE, 8'h00);
    push_panel_item(OP_BYTE, 8'hFE);
    vals = '{8'd0, 8'd0, 8'd0, 8'd255, SYNC_BYTE, 8'd200, 8'd0, 8'd0};
    push_frame(MODE_LIGHT, vals, 5);
    push_ticks(1);
    vals = '{8'd99, 8'd99, 8'd99, 8'd0, 8'd0, 8'd9, 8'd255, 8'd255};
    push_frame(8'd0, vals, 0);
    push_ticks(1);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int choice;
    while (counted_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        push_random_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0);
        // Long tick runs let the scroll position wrap.
        push_ticks(($urandom_range(0, 2) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8));
      end else if (choice == 7) begin
        repeat ($urandom_range(1, 4)) push_panel_item(OP_BYTE, 8'($urandom_range(0, 254)));
      end else if (choice == 8) begin
        // A broken frame: its remaining bytes come from whatever follows.
        push_panel_item(OP_BYTE, SYNC_BYTE);
        repeat ($urandom_range(1, 8)) push_panel_item(OP_BYTE, 8'($urandom_range(0, 255)));
        push_ticks($urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 6))
          push_panel_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
    wait_results_drained();
  endtask

  // The receiver holds off while ticks keep coming, so the unit stalls its input.
  task automatic test_output_backpressure();
    idle_odds = 0;
    rx_hold_cycles = 300;
    push_ticks(20);
    push_random_frame(0);
    push_ticks(10);
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    idle_odds = 0;
    repeat (4) begin
      push_random_frame(0);
      push_ticks($urandom_range(2, 12));
    end
    stop_sending();
  endtask

  initial begin
    reset_panel();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_up_picture();
    test_frame_corners();
    test_random_traffic();
    test_output_backpressure();
    test_back_to_back();
    while (panel_results_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && panel_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
